// ===== src/brenc_pkg.sv =====
// Shared types and constants of the breakpoint region encoder.
// No dependencies; every other file but brenc_ram refers to it by scoped names.
package brenc_pkg;

	localparam int CFG_W     = 9;    // num_regions register
	localparam int SLOT_IN_W = 9;
	localparam int SPACE_W   = 2;
	localparam int FUNC_W    = 4;
	localparam int VALUE_W   = 32;
	localparam int CODE_W    = 8;
	localparam int CODE_MAX  = 255;
	localparam int NR_RESET  = 256;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	typedef struct packed {
		logic                        command;
		logic [SPACE_W-1:0]          space;
		logic [FUNC_W-1:0]           hash_func;
		logic [SLOT_IN_W-1:0]        slot;
		logic signed [VALUE_W-1:0]   value;
		logic                        last;
	} cmd_item_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [SPACE_W-1:0] out_space;
		logic [FUNC_W-1:0]  out_func;
		logic               out_last;
	} res_item_t;

	// Per-item control travelling down the search pipeline.
	typedef struct packed {
		logic                      wr;    // table write that really lands
		logic                      enc;   // encode item
		logic                      sel;   // table selector in range
		logic                      done;  // region already known
		logic [SPACE_W-1:0]        space;
		logic [FUNC_W-1:0]         func;
		logic                      last;
		logic signed [VALUE_W-1:0] value;
	} tag_t;

endpackage

// ===== src/brenc_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module brenc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== src/brenc_edge.sv =====
// Edge test: reads bp[0] and bp[nr] from its own table copy and settles the
// below-first / at-or-above-last cases. Uses brenc_pkg and brenc_ram.
module brenc_edge #(
	parameter int DEPTH = 16448,
	parameter int SLOTS = 257,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [SLOT_W-1:0] nr,
	input  logic              valid_i,
	input  brenc_pkg::tag_t   tag_i,
	input  logic [ADDR_W-1:0] base_i,
	input  logic [SLOT_W-1:0] slot_i,
	output logic              valid_o,
	output brenc_pkg::tag_t   tag_o,
	output logic [ADDR_W-1:0] base_o,
	output logic [SLOT_W-1:0] slot_o,
	output logic [SLOT_W-1:0] lo_o,
	output logic [SLOT_W-1:0] hi_o,
	output logic [SLOT_W-1:0] region_o
);

	logic [brenc_pkg::VALUE_W-1:0] rdata_a;
	logic [brenc_pkg::VALUE_W-1:0] rdata_b;

	logic              valid_s1;
	brenc_pkg::tag_t   tag_s1;
	logic [ADDR_W-1:0] base_s1;
	logic [SLOT_W-1:0] slot_s1;

	brenc_pkg::tag_t   tag_n;
	logic [SLOT_W-1:0] lo_n;
	logic [SLOT_W-1:0] hi_n;
	logic [SLOT_W-1:0] region_n;

	logic              valid_s2;
	brenc_pkg::tag_t   tag_s2;
	logic [ADDR_W-1:0] base_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [SLOT_W-1:0] lo_s2;
	logic [SLOT_W-1:0] hi_s2;
	logic [SLOT_W-1:0] region_s2;

	brenc_ram #(
		.WIDTH(brenc_pkg::VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (en && valid_i && tag_i.wr),
		.waddr   (base_i + ADDR_W'(slot_i)),
		.wdata   (tag_i.value),
		.re      (en),
		.raddr_a (base_i),
		.raddr_b (base_i + ADDR_W'(nr)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1    <= tag_i;
			base_s1   <= base_i;
			slot_s1   <= slot_i;
			tag_s2    <= tag_n;
			base_s2   <= base_s1;
			slot_s2   <= slot_s1;
			lo_s2     <= lo_n;
			hi_s2     <= hi_n;
			region_s2 <= region_n;
		end
	end

	always_comb begin
		tag_n    = tag_s1;
		lo_n     = '0;
		hi_n     = nr;
		region_n = '0;
		if (tag_s1.enc) begin
			priority if (!tag_s1.sel) begin
				tag_n.done = 1'b1;
			end else if (tag_s1.value < $signed(rdata_a)) begin
				tag_n.done = 1'b1;
			end else if (tag_s1.value >= $signed(rdata_b)) begin
				tag_n.done = 1'b1;
				region_n   = nr - SLOT_W'(1);
			end else begin
				tag_n.done = 1'b0;
			end
		end
	end

	assign valid_o  = valid_s2;
	assign tag_o    = tag_s2;
	assign base_o   = base_s2;
	assign slot_o   = slot_s2;
	assign lo_o     = lo_s2;
	assign hi_o     = hi_s2;
	assign region_o = region_s2;

endmodule

// ===== src/brenc_level.sv =====
// One binary-search level: probe address stage, then compare stage, with its
// own table copy written in item order. Uses brenc_pkg and brenc_ram.
module brenc_level #(
	parameter int DEPTH = 16448,
	parameter int SLOTS = 257,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  brenc_pkg::tag_t   tag_i,
	input  logic [ADDR_W-1:0] base_i,
	input  logic [SLOT_W-1:0] slot_i,
	input  logic [SLOT_W-1:0] lo_i,
	input  logic [SLOT_W-1:0] hi_i,
	input  logic [SLOT_W-1:0] region_i,
	output logic              valid_o,
	output brenc_pkg::tag_t   tag_o,
	output logic [ADDR_W-1:0] base_o,
	output logic [SLOT_W-1:0] slot_o,
	output logic [SLOT_W-1:0] lo_o,
	output logic [SLOT_W-1:0] hi_o,
	output logic [SLOT_W-1:0] region_o
);

	logic              active;
	logic [SLOT_W-1:0] mid;
	logic [SLOT_W-1:0] mid1;
	logic [brenc_pkg::VALUE_W-1:0] rdata_a;
	logic [brenc_pkg::VALUE_W-1:0] rdata_b;

	logic              valid_s1;
	logic              active_s1;
	brenc_pkg::tag_t   tag_s1;
	logic [ADDR_W-1:0] base_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [SLOT_W-1:0] lo_s1;
	logic [SLOT_W-1:0] hi_s1;
	logic [SLOT_W-1:0] region_s1;
	logic [SLOT_W-1:0] mid_s1;

	brenc_pkg::tag_t   tag_n;
	logic [SLOT_W-1:0] lo_n;
	logic [SLOT_W-1:0] hi_n;
	logic [SLOT_W-1:0] region_n;

	logic              valid_s2;
	brenc_pkg::tag_t   tag_s2;
	logic [ADDR_W-1:0] base_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [SLOT_W-1:0] lo_s2;
	logic [SLOT_W-1:0] hi_s2;
	logic [SLOT_W-1:0] region_s2;

	// Interval is [lo, hi); probe mid = lo + (hi - 1 - lo) / 2.
	assign active = tag_i.enc && !tag_i.done && (lo_i < hi_i);
	assign mid    = lo_i + ((hi_i - lo_i - SLOT_W'(1)) >> 1);
	assign mid1   = mid + SLOT_W'(1);

	brenc_ram #(
		.WIDTH(brenc_pkg::VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (en && valid_i && tag_i.wr),
		.waddr   (base_i + ADDR_W'(slot_i)),
		.wdata   (tag_i.value),
		.re      (en),
		.raddr_a (base_i + ADDR_W'(mid)),
		.raddr_b (base_i + ADDR_W'(mid1)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			active_s1 <= active;
			tag_s1    <= tag_i;
			base_s1   <= base_i;
			slot_s1   <= slot_i;
			lo_s1     <= lo_i;
			hi_s1     <= hi_i;
			region_s1 <= region_i;
			mid_s1    <= mid;
			tag_s2    <= tag_n;
			base_s2   <= base_s1;
			slot_s2   <= slot_s1;
			lo_s2     <= lo_n;
			hi_s2     <= hi_n;
			region_s2 <= region_n;
		end
	end

	always_comb begin
		tag_n    = tag_s1;
		lo_n     = lo_s1;
		hi_n     = hi_s1;
		region_n = region_s1;
		if (active_s1) begin
			priority if (tag_s1.value >= $signed(rdata_a) &&
					tag_s1.value < $signed(rdata_b)) begin
				tag_n.done = 1'b1;
				region_n   = mid_s1;
			end else if (tag_s1.value < $signed(rdata_a)) begin
				hi_n = mid_s1;
			end else begin
				lo_n = mid_s1 + SLOT_W'(1);
			end
		end
	end

	assign valid_o  = valid_s2;
	assign tag_o    = tag_s2;
	assign base_o   = base_s2;
	assign slot_o   = slot_s2;
	assign lo_o     = lo_s2;
	assign hi_o     = hi_s2;
	assign region_o = region_s2;

endmodule

// ===== src/breakpoint_region_encoder_core.sv =====
// Top level of the breakpoint region encoder.
// Uses brenc_pkg, brenc_edge, brenc_level (and through them brenc_ram).
//
// Maps signed 32-bit hash values to 8-bit region codes against per-space,
// per-function breakpoint tables, one item per clock while the pipeline is
// not frozen. A write item (command 0) stores one breakpoint and returns
// nothing; an encode item (command 1) returns one code plus echoes of space,
// hash_func and last. Items leave in arrival order. The pipeline has two
// input/address stages, two for the edge test, two per binary-search level
// (address, then compare on registered RAM data), and the output register.
// The edge test and every search level hold their own copy of the breakpoint
// memory, written when a write item passes it, so each probe sees exactly
// the earlier writes. The whole pipeline freezes while res_stall holds a waiting
// result; cmd_stall is that freeze. num_regions should only be written with
// the pipeline empty; 0 acts as 1 and values above MAX_REGIONS saturate.
// Table entries have no reset: encode only against written entries.
module breakpoint_region_encoder_core #(
	parameter int SPACES      = 4,
	parameter int FUNCS       = 16,
	parameter int MAX_REGIONS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [brenc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  brenc_pkg::cmd_item_t          cmd_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output brenc_pkg::res_item_t          res_item
);

	localparam int TABLE_SLOTS = MAX_REGIONS + 1;
	localparam int TABLES      = SPACES * FUNCS;
	localparam int DEPTH       = TABLES * TABLE_SLOTS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int IDX_W       = (TABLES > 1) ? $clog2(TABLES) : 1;
	// A search over up to MAX_REGIONS slots needs this many probes.
	localparam int LEVELS      = SLOT_W;
	localparam int NR_RST      = (brenc_pkg::NR_RESET > MAX_REGIONS) ?
		MAX_REGIONS : brenc_pkg::NR_RESET;

	// ---- region count register (stored already clamped) ----
	logic [SLOT_W-1:0] nr_q;
	logic [SLOT_W-1:0] nr_next;

	always_comb begin
		priority if (cfg_wdata == '0) begin
			nr_next = SLOT_W'(1);
		end else if (int'(cfg_wdata) > MAX_REGIONS) begin
			nr_next = SLOT_W'(MAX_REGIONS);
		end else begin
			nr_next = SLOT_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_q <= SLOT_W'(NR_RST);
		end else if (cfg_we) begin
			nr_q <= nr_next;
		end
	end

	// ---- global advance: move unless a finished result is held ----
	logic                 en;
	logic                 res_valid_q;
	brenc_pkg::res_item_t res_item_q;

	assign en        = !res_valid_q || !res_stall;
	assign cmd_stall = !en;

	// ---- stage 1: decode the item ----
	logic            sel_in;
	logic [31:0]     idx_full;
	brenc_pkg::tag_t tag_in;

	assign sel_in   = (int'(cmd_item.space) < SPACES) && (int'(cmd_item.hash_func) < FUNCS);
	assign idx_full = sel_in ?
		(32'(cmd_item.space) * 32'(FUNCS) + 32'(cmd_item.hash_func)) : 32'd0;

	always_comb begin
		tag_in.wr    = (cmd_item.command == brenc_pkg::CMD_WRITE) && sel_in &&
			(int'(cmd_item.slot) <= MAX_REGIONS);
		tag_in.enc   = (cmd_item.command == brenc_pkg::CMD_ENCODE);
		tag_in.sel   = sel_in;
		tag_in.done  = 1'b0;
		tag_in.space = cmd_item.space;
		tag_in.func  = cmd_item.hash_func;
		tag_in.last  = cmd_item.last;
		tag_in.value = cmd_item.value;
	end

	logic              valid_s1;
	brenc_pkg::tag_t   tag_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SLOT_W-1:0] slot_s1;

	// ---- stage 2: table base address ----
	logic              valid_s2;
	brenc_pkg::tag_t   tag_s2;
	logic [ADDR_W-1:0] base_s2;
	logic [SLOT_W-1:0] slot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag_in;
			idx_s1  <= IDX_W'(idx_full);
			// slot beyond MAX_REGIONS never writes, so narrowing is safe
			slot_s1 <= SLOT_W'(cmd_item.slot);
			tag_s2  <= tag_s1;
			base_s2 <= ADDR_W'(32'(idx_s1) * 32'(TABLE_SLOTS));
			slot_s2 <= slot_s1;
		end
	end

	// ---- edge test and search levels ----
	logic              valid_w  [LEVELS+1];
	brenc_pkg::tag_t   tag_w    [LEVELS+1];
	logic [ADDR_W-1:0] base_w   [LEVELS+1];
	logic [SLOT_W-1:0] slot_w   [LEVELS+1];
	logic [SLOT_W-1:0] lo_w     [LEVELS+1];
	logic [SLOT_W-1:0] hi_w     [LEVELS+1];
	logic [SLOT_W-1:0] region_w [LEVELS+1];

	brenc_edge #(
		.DEPTH(DEPTH),
		.SLOTS(TABLE_SLOTS)
	) u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.nr       (nr_q),
		.valid_i  (valid_s2),
		.tag_i    (tag_s2),
		.base_i   (base_s2),
		.slot_i   (slot_s2),
		.valid_o  (valid_w[0]),
		.tag_o    (tag_w[0]),
		.base_o   (base_w[0]),
		.slot_o   (slot_w[0]),
		.lo_o     (lo_w[0]),
		.hi_o     (hi_w[0]),
		.region_o (region_w[0])
	);

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		brenc_level #(
			.DEPTH(DEPTH),
			.SLOTS(TABLE_SLOTS)
		) u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_i  (valid_w[k]),
			.tag_i    (tag_w[k]),
			.base_i   (base_w[k]),
			.slot_i   (slot_w[k]),
			.lo_i     (lo_w[k]),
			.hi_i     (hi_w[k]),
			.region_i (region_w[k]),
			.valid_o  (valid_w[k+1]),
			.tag_o    (tag_w[k+1]),
			.base_o   (base_w[k+1]),
			.slot_o   (slot_w[k+1]),
			.lo_o     (lo_w[k+1]),
			.hi_o     (hi_w[k+1]),
			.region_o (region_w[k+1])
		);
	end

	// ---- output register: only encode items produce a result ----
	// A search that never hit keeps region 0, as does an unselected table.
	brenc_pkg::res_item_t res_n;

	always_comb begin
		res_n.code      = (int'(region_w[LEVELS]) > brenc_pkg::CODE_MAX) ?
			brenc_pkg::CODE_W'(brenc_pkg::CODE_MAX) :
			brenc_pkg::CODE_W'(region_w[LEVELS]);
		res_n.out_space = tag_w[LEVELS].space;
		res_n.out_func  = tag_w[LEVELS].func;
		res_n.out_last  = tag_w[LEVELS].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= valid_w[LEVELS] && tag_w[LEVELS].enc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_item_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// ---- checks ----
	// A search still open after the last level must have an empty interval.
	a_search_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_w[LEVELS] && tag_w[LEVELS].enc && !tag_w[LEVELS].done) |->
		(lo_w[LEVELS] >= hi_w[LEVELS] && region_w[LEVELS] == '0))
		else $error("search left open with a live interval or nonzero region");

	// Encodes against an out-of-range table come out with region 0.
	a_unselected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_w[LEVELS] && tag_w[LEVELS].enc && !tag_w[LEVELS].sel) |->
		(region_w[LEVELS] == '0))
		else $error("unselected table produced a nonzero region");

	// A held result freezes the whole pipeline.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=>
		($stable(valid_s1) && $stable(valid_s2) && $stable(valid_w[LEVELS])))
		else $error("pipeline moved while the output was stalled");

endmodule

// ===== dv/tb_breakpoint_region_encoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for breakpoint_region_encoder_core: breakpoint table loads,
// region encodes and region-count settings, under random sender gaps and receiver stalls.
// Depends on brenc_pkg and the core RTL only.

module tb_breakpoint_region_encoder_core;

	localparam int N_SPACES    = 4;
	localparam int N_FUNCS     = 16;
	localparam int MAX_REG     = 256;
	localparam int SLOT_TOP    = (1 << brenc_pkg::SLOT_IN_W) - 1;
	localparam int PIPE_DEPTH  = 2 * $clog2(MAX_REG + 1) + 5;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX  = 10;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// All inputs start at known values; afterwards they only change at rising edges.
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [brenc_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic                        cmd_valid = 1'b0;
	logic                        cmd_stall;
	brenc_pkg::cmd_item_t        cmd_item  = '0;
	logic                        res_valid;
	logic                        res_stall = 1'b0;
	brenc_pkg::res_item_t        res_item;

	breakpoint_region_encoder_core #(
		.SPACES(N_SPACES),
		.FUNCS(N_FUNCS),
		.MAX_REGIONS(MAX_REG)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	always #1 clk = ~clk;

	// Shadow copy of the breakpoint tables and the region count.
	logic signed [brenc_pkg::VALUE_W-1:0] bp_mem [N_SPACES][N_FUNCS][MAX_REG+1];
	bit                        bp_written [N_SPACES][N_FUNCS][MAX_REG+1];
	int                        filled_prefix [N_SPACES][N_FUNCS];  // slots 0..n-1 all written
	int                        nr_reg = brenc_pkg::NR_RESET;

	brenc_pkg::res_item_t pending_codes [$];
	brenc_pkg::res_item_t head_code;
	int        sender_idle_pct = 0;
	int        stall_pct       = 0;
	int        mismatches      = 0;
	int        n_checked       = 0;
	int        n_writes        = 0;
	int        n_dropped       = 0;
	int        n_encodes       = 0;
	int        cycles          = 0;

	// Region count as the search sees it: 0 acts as 1, above MAX_REG saturates.
	function automatic int regions_in_use();
		if (nr_reg < 1)
			return 1;
		if (nr_reg > MAX_REG)
			return MAX_REG;
		return nr_reg;
	endfunction

	// Fixed binary search: edge tests first, then probes until bp[m] <= v < bp[m+1].
	// Unsorted tables follow the same probe path; an emptied interval yields 0.
	function automatic int predict_region(int sp, int fn,
	                                      logic signed [brenc_pkg::VALUE_W-1:0] v);
		int nr, lo_i, hi_i, mid;
		nr   = regions_in_use();
		lo_i = 0;
		hi_i = nr - 1;
		if (v < bp_mem[sp][fn][0])
			return 0;
		if (v >= bp_mem[sp][fn][nr])
			return nr - 1;
		while (lo_i <= hi_i) begin
			mid = lo_i + (hi_i - lo_i) / 2;
			if (v >= bp_mem[sp][fn][mid] && v < bp_mem[sp][fn][mid+1])
				return mid;
			if (v < bp_mem[sp][fn][mid])
				hi_i = mid - 1;
			else
				lo_i = mid + 1;
		end
		return 0;
	endfunction

	// Apply an accepted item to the shadow state; encodes queue their expected code.
	task automatic commit_item(input brenc_pkg::cmd_item_t it);
		brenc_pkg::res_item_t r;
		int        sp, fn, region;
		sp = it.space;
		fn = it.hash_func;
		if (it.command == brenc_pkg::CMD_WRITE) begin
			if (it.slot <= MAX_REG) begin
				bp_mem[sp][fn][it.slot]     = it.value;
				bp_written[sp][fn][it.slot] = 1'b1;
				while (filled_prefix[sp][fn] <= MAX_REG &&
				       bp_written[sp][fn][filled_prefix[sp][fn]])
					filled_prefix[sp][fn]++;
				n_writes++;
			end else begin
				n_dropped++;
			end
		end else begin
			region      = predict_region(sp, fn, it.value);
			r.code      = (region > brenc_pkg::CODE_MAX) ?
				brenc_pkg::CODE_W'(brenc_pkg::CODE_MAX) : brenc_pkg::CODE_W'(region);
			r.out_space = it.space;
			r.out_func  = it.hash_func;
			r.out_last  = it.last;
			pending_codes.insert(pending_codes.size(), r);
			n_encodes++;
		end
	endtask

	// Offer one item, with random idle cycles in front, and hold it until accepted.
	task automatic send_item(input brenc_pkg::cmd_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		commit_item(it);
	endtask

	task automatic send_write(input int sp, input int fn, input int slot,
	                          input logic [brenc_pkg::VALUE_W-1:0] val);
		brenc_pkg::cmd_item_t it;
		it.command   = brenc_pkg::CMD_WRITE;
		it.space     = sp[brenc_pkg::SPACE_W-1:0];
		it.hash_func = fn[brenc_pkg::FUNC_W-1:0];
		it.slot      = slot[brenc_pkg::SLOT_IN_W-1:0];
		it.value     = val;
		it.last      = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic send_encode(input int sp, input int fn,
	                           input logic [brenc_pkg::VALUE_W-1:0] val, input logic lst);
		brenc_pkg::cmd_item_t it;
		it.command   = brenc_pkg::CMD_ENCODE;
		it.space     = sp[brenc_pkg::SPACE_W-1:0];
		it.hash_func = fn[brenc_pkg::FUNC_W-1:0];
		// don't care on encode
		it.slot      = brenc_pkg::SLOT_IN_W'($urandom_range(0, SLOT_TOP));
		it.value     = val;
		it.last      = lst;
		send_item(it);
	endtask

	// Stop offering, wait out every expected code, then let trailing writes clear.
	task automatic drain_pipeline();
		cmd_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4)
			@(posedge clk);
	endtask

	task automatic write_regions(input int n);
		cfg_we    <= 1'b1;
		cfg_wdata <= n[brenc_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		nr_reg    = n;
	endtask

	// Random traffic: mostly sorted table loads followed by encodes on fully loaded
	// tables, plus stray writes (unsorting entries, dropped out-of-range slots).
	task automatic run_stream(input int budget);
		int                        sent, pick, nr, sp, fn, k, slot;
		int                        ready_sp [$];
		int                        ready_fn [$];
		longint                    cur, step_max;
		logic signed [brenc_pkg::VALUE_W-1:0] v;
		sent = 0;
		while (sent < budget) begin
			nr = regions_in_use();
			ready_sp.delete();
			ready_fn.delete();
			for (int i = 0; i < N_SPACES; i++)
				for (int j = 0; j < N_FUNCS; j++)
					if (filled_prefix[i][j] > nr) begin
						ready_sp.insert(ready_sp.size(), i);
						ready_fn.insert(ready_fn.size(), j);
					end
			pick = $urandom_range(0, 99);
			if (ready_sp.size() == 0 || (pick < 8 && nr <= 64)) begin
				// Non-decreasing load of slots 0..nr, clamped at the top so duplicates show up.
				sp = $urandom_range(0, N_SPACES - 1);
				fn = $urandom_range(0, N_FUNCS - 1);
				case ($urandom_range(0, 2))
					0: begin
						step_max = 7;
						cur      = longint'($urandom) - 64'sd2147483648;
					end
					1: begin
						step_max = 64'd4294967295 / (nr + 1);
						cur      = longint'($urandom_range(0, step_max[31:0])) -
							64'sd2147483648;
					end
					default: begin
						step_max = 100000;
						cur      = longint'($urandom) - 64'sd2147483648;
					end
				endcase
				for (int s = 0; s <= nr; s++) begin
					if (cur > 64'sd2147483647)
						cur = 64'sd2147483647;
					send_write(sp, fn, s, cur[31:0]);
					cur += longint'($urandom_range(0, step_max[31:0]));
				end
				sent += nr + 1;
			end else if (pick < 22) begin
				case ($urandom_range(0, 3))
					0:       slot = $urandom_range(MAX_REG + 1, SLOT_TOP);  // dropped
					1:       slot = $urandom_range(0, nr);
					default: slot = $urandom_range(0, MAX_REG);
				endcase
				send_write($urandom_range(0, N_SPACES - 1), $urandom_range(0, N_FUNCS - 1),
				           slot, $urandom);
				sent++;
			end else begin
				k  = $urandom_range(0, ready_sp.size() - 1);
				sp = ready_sp[k];
				fn = ready_fn[k];
				case ($urandom_range(0, 4))
					0, 1: v = bp_mem[sp][fn][$urandom_range(0, nr)] +
						(int'($urandom_range(0, 2)) - 1);
					2:    v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					default: v = $urandom;
				endcase
				send_encode(sp, fn, v, 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin sender_idle_pct = 46; stall_pct = 0;  end
			IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 46; end
			IDLE_BOTH:     begin sender_idle_pct = 29; stall_pct = 29; end
			default:       begin sender_idle_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// One setting of the region count: quiesce, reprogram, then random traffic.
	task automatic run_phase(input int n, input idle_mode_t mode, input int budget);
		drain_pipeline();
		set_idling(mode);
		write_regions(n);
		run_stream(budget);
	endtask

	// Hand-picked loads and probes: value extremes, exact hits on breakpoints,
	// duplicate breakpoints, slot MAX_REG stored but unused, out-of-range slots dropped.
	task automatic test_directed();
		set_idling(IDLE_NONE);
		write_regions(4);
		send_write(3, 15, 0, 32'sh8000_0000);
		send_write(3, 15, 1, -32'sd10);
		send_write(3, 15, 2, 32'sd0);
		send_write(3, 15, 3, 32'sd10);
		send_write(3, 15, 4, 32'sh7FFF_FFFF);
		send_write(3, 15, MAX_REG, 32'sd123);
		send_write(3, 15, MAX_REG + 1, 32'sd1000);  // would land on slot 0 if the index wrapped
		send_write(3, 15, SLOT_TOP, -32'sd1);
		send_encode(3, 15, 32'sh8000_0000, 1'b0);
		send_encode(3, 15, -32'sd11, 1'b1);
		send_encode(3, 15, -32'sd10, 1'b0);
		send_encode(3, 15, -32'sd1, 1'b1);
		send_encode(3, 15, 32'sd0, 1'b0);
		send_encode(3, 15, 32'sd10, 1'b1);
		send_encode(3, 15, 32'sh7FFF_FFFF, 1'b1);
		// run of equal breakpoints
		send_write(0, 0, 0, 32'sd5);
		send_write(0, 0, 1, 32'sd5);
		send_write(0, 0, 2, 32'sd5);
		send_write(0, 0, 3, 32'sd7);
		send_write(0, 0, 4, 32'sd7);
		send_encode(0, 0, 32'sd4, 1'b0);
		send_encode(0, 0, 32'sd5, 1'b1);
		send_encode(0, 0, 32'sd6, 1'b0);
		send_encode(0, 0, 32'sd7, 1'b1);
	endtask

	// Region count 0 (acts as one region) and exactly one region.
	task automatic test_degenerate_counts();
		run_phase(0, IDLE_NONE, 150);
		run_phase(1, IDLE_SENDER, 150);
	endtask

	task automatic test_small_tables();
		run_phase(2, IDLE_RECEIVER, 200);
		run_phase(7, IDLE_BOTH, 200);
		run_phase(16, IDLE_NONE, 200);
	endtask

	// Full 257-entry tables, then a count above MAX_REG that must saturate.
	task automatic test_full_tables();
		run_phase(MAX_REG, IDLE_BOTH, 400);
		run_phase(SLOT_TOP, IDLE_RECEIVER, 150);
	endtask

	task automatic test_random_counts();
		run_phase($urandom_range(3, 64), IDLE_SENDER, 150);
		run_phase($urandom_range(3, 64), IDLE_BOTH, 150);
		run_phase($urandom_range(3, 64), IDLE_NONE, 150);
	endtask

	// Receiver backpressure, redrawn every cycle.
	always @(posedge clk)
		res_stall <= ($urandom_range(0, 99) < stall_pct);

	// Result checker: every accepted result against the oldest expected code.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0d] unexpected result code=%0d space=%0d func=%0d last=%0d",
					         cycles, res_item.code, res_item.out_space, res_item.out_func,
					         res_item.out_last);
			end else begin
				head_code = pending_codes.pop_front();
				n_checked++;
				if (res_item.code !== head_code.code ||
				    res_item.out_space !== head_code.out_space ||
				    res_item.out_func !== head_code.out_func ||
				    res_item.out_last !== head_code.out_last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0d] mismatch: expected code=%0d space=%0d func=%0d last=%0d,",
						         cycles, head_code.code, head_code.out_space,
						         head_code.out_func, head_code.out_last,
						         " got code=%0d space=%0d func=%0d last=%0d",
						         res_item.code, res_item.out_space, res_item.out_func,
						         res_item.out_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d codes outstanding", cycles,
			         pending_codes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_degenerate_counts();
		test_small_tables();
		test_full_tables();
		test_random_counts();
		drain_pipeline();
		$display("%0d breakpoint writes (%0d out-of-range slots dropped), %0d encodes;",
		         n_writes, n_dropped, n_encodes);
		$display("region counts 0, 1, small, %0d and %0d; %0d codes checked, %0d mismatches",
		         MAX_REG, SLOT_TOP, n_checked, mismatches);
		if (mismatches == 0 && pending_codes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
src/brenc_pkg.sv
src/brenc_ram.sv
src/brenc_edge.sv
src/brenc_level.sv
src/breakpoint_region_encoder_core.sv
dv/tb_breakpoint_region_encoder_core.sv
